@@ src/rfr_pkg.sv @@
// rfr_pkg: shared types, constants and build-time coefficient functions
// for the rational fir resampler. No dependencies.
`default_nettype none

package rfr_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int TAP_COUNT_DEF = 63;
  localparam int COEF_BITS_DEF = 18;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  // register index, taken from the word address
  localparam logic REG_RATE_MODE = 1'b0;

  // saturation limits of the output sample
  localparam int SAT_POS = 32767;
  localparam int SAT_NEG = 32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_ISSUE,
    ST_DRAIN,
    ST_PUSH
  } rfr_state_t;

  typedef struct packed {
    logic clr;
    logic tap_vld;
  } mac_ctrl_t;

  // filter design constants (Q30 fixed point)
  localparam longint FixOne    = 64'sd1073741824;
  localparam longint PiFix     = 64'sd3373259426;
  localparam longint HalfPiFix = 64'sd1686629713;
  localparam longint CutNum    = 64'sd7;
  localparam longint CutDen    = 64'sd48;

  // sine of a Q32 fraction of a turn, Q30 result, Taylor series
  function automatic longint sine_of_turn(input logic [31:0] f);
    logic [1:0] quad;
    longint r;
    longint a;
    longint term;
    longint s;
    longint Den;
    int n;
    quad = f[31:30];
    r = longint'(f[29:0]);
    if (quad[0]) begin
      r = FixOne - r;
    end
    a = (r * HalfPiFix) / FixOne;
    term = a;
    s = a;
    for (n = 1; n <= 12; n++) begin
      Den = longint'((2 * n) * (2 * n + 1));
      term = ((term * a) / FixOne) * a / FixOne;
      term = -term / Den;
      s = s + term;
    end
    return quad[1] ? -s : s;
  endfunction

  // (Num mod Den) / Den as a Q32 fraction of a turn
  function automatic logic [31:0] turn_of(input longint Num, input longint Den);
    longint q;
    q = ((Num % Den) <<< 32) / Den;
    return 32'(q);
  endfunction

  // windowed sinc tap before normalisation
  function automatic longint tap_raw(input int Taps, input int Idx);
    longint Span;
    longint mid;
    longint x;
    longint ax;
    longint s;
    longint Div;
    longint sinc;
    longint c1;
    longint c2;
    longint w;
    logic [31:0] f1;
    logic [31:0] f2;
    Span = longint'(Taps - 1);
    mid = longint'((Taps - 1) / 2);
    x = longint'(Idx) - mid;
    ax = (x < 0) ? -x : x;
    if (ax == 0) begin
      sinc = (2 * CutNum * FixOne) / CutDen;
    end else begin
      s = sine_of_turn(turn_of(CutNum * ax, CutDen));
      Div = PiFix * ax;
      sinc = (s * FixOne) / Div;
    end
    f1 = turn_of(longint'(Idx), Span) + 32'h4000_0000;
    f2 = turn_of(2 * longint'(Idx), Span) + 32'h4000_0000;
    c1 = sine_of_turn(f1);
    c2 = sine_of_turn(f2);
    w = (42 * FixOne) / 100 - c1 / 2 + (8 * c2) / 100;
    return (sinc * w) / FixOne;
  endfunction

  // normalising divisor, forced to one when not positive
  function automatic longint coef_sum(input int Taps);
    longint sum;
    int j;
    sum = 0;
    for (j = 0; j < Taps; j++) begin
      sum = sum + tap_raw(Taps, j);
    end
    return (sum <= 0) ? 64'sd1 : sum;
  endfunction

  // final tap: scaled by the up factor, rounded half away, saturated
  function automatic longint coef_value(input int Taps, input int Cbits, input int Up,
                                        input int Idx, input longint Sum);
    longint num;
    longint mag;
    longint q;
    longint cmax;
    longint cmin;
    cmax = (64'sd1 <<< (Cbits - 1)) - 1;
    cmin = -(64'sd1 <<< (Cbits - 1));
    num = tap_raw(Taps, Idx) * longint'(Up) * (64'sd1 <<< (Cbits - 1));
    mag = (num < 0) ? -num : num;
    q = (mag + Sum / 2) / Sum;
    if (num < 0) begin
      q = -q;
    end
    if (q > cmax) begin
      q = cmax;
    end
    if (q < cmin) begin
      q = cmin;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

@@ src/rfr_ram.sv @@
// rfr_ram: generic single-write, single-read synchronous ram with
// registered read data. No dependencies.
`default_nettype none

module rfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/rfr_mac.sv @@
// rfr_mac: tap multiplier, accumulator and output rounding/saturation.
// Depends on rfr_pkg.
`default_nettype none

module rfr_mac #(
  parameter int TAP_COUNT = rfr_pkg::TAP_COUNT_DEF,
  parameter int COEF_BITS = rfr_pkg::COEF_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire rfr_pkg::mac_ctrl_t                    mctl,
  input  wire logic signed [rfr_pkg::SAMPLE_W-1:0]   samp,
  input  wire logic signed [COEF_BITS-1:0]           coef,
  output logic signed      [rfr_pkg::SAMPLE_W-1:0]   result
);
  import rfr_pkg::*;

  localparam int ProdW = SAMPLE_W + COEF_BITS;
  localparam int AccW  = ProdW + $clog2(TAP_COUNT);
  localparam int Frac  = COEF_BITS - 1;
  localparam logic [AccW:0] HalfLsb = (AccW + 1)'(1) << (Frac - 1);
  localparam logic [AccW:0] SatPos  = (AccW + 1)'(SAT_POS);
  localparam logic [AccW:0] SatNeg  = (AccW + 1)'(SAT_NEG);

  logic signed [ProdW-1:0] prod_nxt;
  logic signed [ProdW-1:0] prod_r;
  logic                    prod_vld_r;
  logic signed [AccW-1:0]  acc_r;
  logic [AccW-1:0]         mag;
  logic [AccW:0]           rnd;
  logic                    neg;

  assign prod_nxt = ProdW'(samp) * ProdW'(coef);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= mctl.tap_vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (mctl.clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + AccW'(prod_r);
    end
  end

  // round half away from zero on the magnitude, then restore the sign
  always_comb begin
    neg = acc_r[AccW-1];
    mag = neg ? $unsigned(~acc_r + 1'b1) : $unsigned(acc_r);
    rnd = ({1'b0, mag} + HalfLsb) >> Frac;
    if (!neg) begin
      result = (rnd > SatPos) ? SAMPLE_W'(SAT_POS) : rnd[SAMPLE_W-1:0];
    end else begin
      result = (rnd > SatNeg) ? SAMPLE_W'(SAT_NEG) : (~rnd[SAMPLE_W-1:0] + 1'b1);
    end
  end

endmodule

`default_nettype wire

@@ src/rfr_ctrl.sv @@
// rfr_ctrl: tick sequencer, sample history ram with valid bits, tap
// address generation. Depends on rfr_pkg and rfr_ram.
`default_nettype none

module rfr_ctrl #(
  parameter int TAP_COUNT = rfr_pkg::TAP_COUNT_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 mode,
  input  wire logic                                 clear,
  input  wire logic                                 in_valid,
  input  wire logic signed [rfr_pkg::SAMPLE_W-1:0]  in_data,
  output logic                                      in_ready,
  input  wire logic                                 out_free,
  output logic                                      res_load,
  output logic                                      res_last,
  output logic [$clog2(2*TAP_COUNT)-1:0]            coef_idx,
  output logic signed [rfr_pkg::SAMPLE_W-1:0]       samp,
  output rfr_pkg::mac_ctrl_t                        mctl
);
  import rfr_pkg::*;

  localparam int PtrW  = $clog2(TAP_COUNT);
  localparam int CidxW = $clog2(2 * TAP_COUNT);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(TAP_COUNT - 1);

  rfr_state_t state_r, state_nxt;
  logic [PtrW-1:0]            wp_r, wp_nxt;
  logic [PtrW-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [PtrW-1:0]            issue_r, issue_nxt;
  logic [1:0]                 phase_r, phase_nxt;
  logic [1:0]                 tick_r, tick_nxt;
  logic                       drain_r, drain_nxt;
  logic                       last_r, last_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [TAP_COUNT-1:0]       vld_r, vld_nxt;
  logic                       hit_vld_r;
  logic                       tap_vld_r;
  logic                       clr;
  logic                       ram_we;
  logic [SAMPLE_W-1:0]        ram_wdata;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic [1:0]                 up_m1;
  logic [1:0]                 down_m1;
  logic [2:0]                 ticks_left;

  // mode 1: up 3 down 2, mode 0: up 2 down 3
  assign up_m1      = mode ? 2'd2 : 2'd1;
  assign down_m1    = mode ? 2'd1 : 2'd2;
  assign ticks_left = {1'b0, up_m1} - {1'b0, tick_r};

  rfr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TAP_COUNT)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign ram_wdata = (tick_r == 2'd0) ? sample_r : '0;
  // entries never written since the last clear read as zero
  assign samp      = hit_vld_r ? ram_rdata : '0;
  assign coef_idx  = mode ? (CidxW'(TAP_COUNT) + CidxW'(issue_r)) : CidxW'(issue_r);
  assign res_last  = last_r;
  assign mctl.clr     = clr;
  assign mctl.tap_vld = tap_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wp_r      <= '0;
      rd_ptr_r  <= '0;
      issue_r   <= '0;
      phase_r   <= '0;
      tick_r    <= '0;
      drain_r   <= 1'b0;
      last_r    <= 1'b0;
      vld_r     <= '0;
      hit_vld_r <= 1'b0;
      tap_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wp_r      <= wp_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      issue_r   <= issue_nxt;
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      drain_r   <= drain_nxt;
      last_r    <= last_nxt;
      vld_r     <= vld_nxt;
      hit_vld_r <= vld_r[rd_ptr_r];
      tap_vld_r <= (state_r == ST_ISSUE);
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    rd_ptr_nxt = rd_ptr_r;
    issue_nxt  = issue_r;
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    drain_nxt  = drain_r;
    last_nxt   = last_r;
    sample_nxt = sample_r;
    vld_nxt    = vld_r;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    res_load   = 1'b0;
    clr        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sample_nxt = in_data;
          tick_nxt   = 2'd0;
          state_nxt  = ST_TICK;
        end
      end
      ST_TICK: begin
        ram_we        = 1'b1;
        vld_nxt[wp_r] = 1'b1;
        wp_nxt        = (wp_r == LastPtr) ? '0 : wp_r + 1'b1;
        if (phase_r == down_m1) begin
          phase_nxt  = 2'd0;
          rd_ptr_nxt = wp_r;
          issue_nxt  = '0;
          clr        = 1'b1;
          // another result follows only if a full down period of ticks remains
          last_nxt   = ({1'b0, ticks_left} < {2'b0, down_m1} + 3'd1);
          state_nxt  = ST_ISSUE;
        end else begin
          phase_nxt = phase_r + 2'd1;
          if (tick_r == up_m1) begin
            state_nxt = ST_IDLE;
          end else begin
            tick_nxt = tick_r + 2'd1;
          end
        end
      end
      ST_ISSUE: begin
        rd_ptr_nxt = (rd_ptr_r == '0) ? LastPtr : rd_ptr_r - 1'b1;
        issue_nxt  = issue_r + 1'b1;
        if (issue_r == LastPtr) begin
          drain_nxt = 1'b0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          res_load = 1'b1;
          if (tick_r == up_m1) begin
            state_nxt = ST_IDLE;
          end else begin
            tick_nxt  = tick_r + 2'd1;
            state_nxt = ST_TICK;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (clear) begin
      wp_nxt    = '0;
      phase_nxt = 2'd0;
      vld_nxt   = '0;
    end
  end

endmodule

`default_nettype wire

@@ src/rational_fir_resampler.sv @@
// rational_fir_resampler: top level, mode register, coefficient rom and
// output register. Depends on rfr_pkg, rfr_ctrl, rfr_mac, rfr_ram.
//
// channel  dir  handshake             payload
// in_      in   tvalid / tready       tdata[15:0] sample_in
// out_     out  tvalid / tready       tdata[15:0] sample_out, tlast = last
// cfg_     in   psel/penable/pwrite   paddr 0: rate_mode in pwdata[0]
//
// an input is zero-stuffed into up ticks written to the history ram; a tick that
// ends a down period starts a result (one or two per input in mode 1, at most one
// in mode 0), read one tap per cycle through the ram's single read port.
// reset and a rate_mode write clear the history valid bits at once, no sweep.
// a finished result waits in the sequencer while the output register is held.
`default_nettype none

module rational_fir_resampler #(
  parameter int TAP_COUNT = rfr_pkg::TAP_COUNT_DEF,
  parameter int COEF_BITS = rfr_pkg::COEF_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [rfr_pkg::SAMPLE_W-1:0]       in_tdata,   // [15:0] sample_in
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [rfr_pkg::SAMPLE_W-1:0]            out_tdata,  // [15:0] sample_out
  output logic                                    out_tlast,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [rfr_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [rfr_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [rfr_pkg::CFG_DATA_W-1:0]          cfg_prdata,
  output logic                                    cfg_pready
);
  import rfr_pkg::*;

  localparam int     CidxW  = $clog2(2 * TAP_COUNT);
  localparam longint TapSum = coef_sum(TAP_COUNT);

  logic                        mode_r;
  logic                        cfg_wr;
  logic                        reg_idx;
  logic                        res_load;
  logic                        res_last;
  logic                        out_free;
  logic [CidxW-1:0]            coef_idx;
  logic signed [COEF_BITS-1:0] coef_r;
  logic signed [COEF_BITS-1:0] coef_rom [2*TAP_COUNT];
  logic signed [SAMPLE_W-1:0]  samp;
  logic signed [SAMPLE_W-1:0]  result;
  mac_ctrl_t                   mctl;
  logic                        out_tvalid_r;
  logic [SAMPLE_W-1:0]         out_data_r;
  logic                        out_last_r;

  // configuration port
  assign reg_idx    = cfg_paddr[2];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & (reg_idx == REG_RATE_MODE);
  assign cfg_prdata = (reg_idx == REG_RATE_MODE) ? {{(CFG_DATA_W-1){1'b0}}, mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  // coefficient rom: first half for up 2, second half for up 3
  for (genvar g = 0; g < 2 * TAP_COUNT; g++) begin : g_rom
    localparam int Up = (g >= TAP_COUNT) ? 3 : 2;
    localparam logic signed [COEF_BITS-1:0] Val =
      COEF_BITS'(coef_value(TAP_COUNT, COEF_BITS, Up, g % TAP_COUNT, TapSum));
    assign coef_rom[g] = Val;
  end

  always_ff @(posedge clk) begin
    coef_r <= coef_rom[coef_idx];
  end

  rfr_ctrl #(
    .TAP_COUNT (TAP_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .clear    (cfg_wr),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .in_ready (in_tready),
    .out_free (out_free),
    .res_load (res_load),
    .res_last (res_last),
    .coef_idx (coef_idx),
    .samp     (samp),
    .mctl     (mctl)
  );

  rfr_mac #(
    .TAP_COUNT (TAP_COUNT),
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .mctl   (mctl),
    .samp   (samp),
    .coef   (coef_r),
    .result (result)
  );

  // output register
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= result;
      out_last_r <= res_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_tvalid_r || out_tready))
    else $error("result loaded over a held transfer");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !mctl.tap_vld)
    else $error("input taken while taps are in flight");

  a_tick_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !res_load)
    else $error("result produced before the history write");

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(res_load))
    else $error("output valid without a result load");

endmodule

`default_nettype wire
